// ----- hdl/rcm_pkg.sv -----
// Shared constants, types and the control-store program of the RMS current meter.
`timescale 1ns / 1ps

package rcm_pkg;

  // Field and register widths
  localparam int AdcBits     = 12;
  localparam int FracBits    = 12;
  localparam int OffsetBits  = AdcBits + FracBits;
  localparam int MagBits     = AdcBits + 4;
  localparam int WindowBits  = 16;
  localparam int GainBits    = 24;
  localparam int SumBits     = 50;
  localparam int RootBits    = SumBits / 2;
  localparam int ProdBits    = RootBits + GainBits;
  localparam int CurrentBits = 32;
  localparam int CountsBits  = 16;
  localparam int CfgBits     = 24;
  localparam int CfgIdxBits  = 1;

  // Iteration counts of the shared divide and square-root steps
  localparam int DivSteps  = SumBits;
  localparam int SqrtSteps = RootBits;
  localparam int IterBits  = $clog2(DivSteps);

  // Reset values of the state and the registers
  localparam logic [OffsetBits-1:0] OffsetReset = OffsetBits'(1) << (OffsetBits - 1);
  localparam logic [WindowBits-1:0] WindowReset = WindowBits'(30000);
  localparam logic [GainBits-1:0]   GainReset   = GainBits'(5856);

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegWindowLength = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegCurrentGain  = 1'b1;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_TAKE,
    OP_OFFSET,
    OP_MAG,
    OP_SQUARE,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_GAIN,
    OP_EMIT
  } op_t;

  // How the step counter moves on
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_LOOP,
    COND_END,
    COND_WAIT_OUT
  } cond_t;

  typedef logic [3:0] step_t;

  // Program addresses
  localparam step_t StepTake     = 4'd0;
  localparam step_t StepOffset   = 4'd1;
  localparam step_t StepMag      = 4'd2;
  localparam step_t StepSquare   = 4'd3;
  localparam step_t StepAccum    = 4'd4;
  localparam step_t StepDivInit  = 4'd5;
  localparam step_t StepDiv      = 4'd6;
  localparam step_t StepSqrtInit = 4'd7;
  localparam step_t StepSqrt     = 4'd8;
  localparam step_t StepGain     = 4'd9;
  localparam step_t StepEmit     = 4'd10;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Control store: one word per step
  function automatic ctrl_t micro_word(step_t pc);
    ctrl_t w;
    unique case (pc)
      StepTake:     w = '{op: OP_TAKE,      cond: COND_WAIT_IN,  target: StepOffset};
      StepOffset:   w = '{op: OP_OFFSET,    cond: COND_NEXT,     target: StepMag};
      StepMag:      w = '{op: OP_MAG,       cond: COND_NEXT,     target: StepSquare};
      StepSquare:   w = '{op: OP_SQUARE,    cond: COND_NEXT,     target: StepAccum};
      StepAccum:    w = '{op: OP_ACCUM,     cond: COND_END,      target: StepDivInit};
      StepDivInit:  w = '{op: OP_DIV_INIT,  cond: COND_NEXT,     target: StepDiv};
      StepDiv:      w = '{op: OP_DIV_STEP,  cond: COND_LOOP,     target: StepSqrtInit};
      StepSqrtInit: w = '{op: OP_SQRT_INIT, cond: COND_NEXT,     target: StepSqrt};
      StepSqrt:     w = '{op: OP_SQRT_STEP, cond: COND_LOOP,     target: StepGain};
      StepGain:     w = '{op: OP_GAIN,      cond: COND_NEXT,     target: StepEmit};
      StepEmit:     w = '{op: OP_EMIT,      cond: COND_WAIT_OUT, target: StepTake};
      default:      w = '{op: OP_TAKE,      cond: COND_NEXT,     target: StepTake};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/rcm_if.sv -----
// Valid/ready channels for ADC sample requests and RMS result requests.
`timescale 1ns / 1ps

interface rcm_sample_if;
  logic                       valid;
  logic                       ready;
  logic [rcm_pkg::AdcBits-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface rcm_result_if;
  logic                            valid;
  logic                            ready;
  logic [rcm_pkg::CurrentBits-1:0] rms_current;
  logic [rcm_pkg::CountsBits-1:0]  rms_counts;

  modport source (output valid, output rms_current, output rms_counts, input ready);
  modport sink (input valid, input rms_current, input rms_counts, output ready);
endinterface

// ----- hdl/rms_current_meter_core.sv -----
// Top level of the RMS current meter: microcoded sequencer over a shared datapath.
`timescale 1ns / 1ps

// Channel   Dir  Payload                      Handshake
// sample    in   adc_sample[11:0]             sample.valid / sample.ready
// result    out  rms_current[31:0],           result.valid / result.ready
//                rms_counts[15:0]
// cfg       in   cfg_index[0], cfg_data[23:0] cfg_we, no wait
//
// A sample passes through the control-store steps take, offset, magnitude,
// square and accumulate. The sample that closes a window then also runs the
// bit-serial divide of the 50-bit sum and the bit-pair square root to a 25-bit
// root, plus setup, gain product and load of the output register.
// Reset is synchronous; it restores the offset to mid-scale and clears the sum.
// The output register holds a result until taken; the sequencer stalls at the
// load step when a previous result is still waiting, and waits at the take step for a sample.

module rms_current_meter_core (
  input  logic                             clk,
  input  logic                             rst,
  rcm_sample_if.sink                       sample,
  rcm_result_if.source                     result,
  input  logic                             cfg_we,
  input  logic [rcm_pkg::CfgIdxBits-1:0]   cfg_index,
  input  logic [rcm_pkg::CfgBits-1:0]      cfg_data
);

  // Sequencer state
  rcm_pkg::step_t                 pc;
  rcm_pkg::step_t                 pc_next;
  rcm_pkg::ctrl_t                 cw;
  logic [rcm_pkg::IterBits-1:0]   iter;

  // Configuration and block state
  logic [rcm_pkg::WindowBits-1:0] window_length;
  logic [rcm_pkg::GainBits-1:0]   current_gain;
  logic [rcm_pkg::OffsetBits-1:0] dc_offset;
  logic [rcm_pkg::SumBits-1:0]    square_sum;
  logic [rcm_pkg::WindowBits-1:0] sample_count;

  // Datapath registers
  logic [rcm_pkg::AdcBits-1:0]    sample_reg;
  logic [rcm_pkg::MagBits-1:0]    mag;
  logic [rcm_pkg::ProdBits-1:0]   product;
  logic [rcm_pkg::WindowBits-1:0] divisor;
  logic [rcm_pkg::WindowBits-1:0] rem;
  logic [rcm_pkg::SumBits-1:0]    quo;
  logic [rcm_pkg::RootBits:0]     sq_rem;
  logic [rcm_pkg::RootBits-1:0]   root;

  // Output register
  logic                           out_valid;
  logic [rcm_pkg::CurrentBits-1:0] out_current;
  logic [rcm_pkg::CountsBits-1:0] out_counts;

  // Combinational datapath signals
  logic                           take;
  logic                           out_free;
  logic [rcm_pkg::OffsetBits-1:0] scaled;
  logic signed [rcm_pkg::OffsetBits:0] diff;
  logic signed [rcm_pkg::OffsetBits:0] offset_step;
  logic [rcm_pkg::OffsetBits:0]   offset_sum;
  logic signed [rcm_pkg::MagBits:0] filt;
  logic [rcm_pkg::MagBits:0]      filt_abs;
  logic [rcm_pkg::RootBits-1:0]   mult_a;
  logic [rcm_pkg::GainBits-1:0]   mult_b;
  logic [rcm_pkg::WindowBits:0]   count_wide;
  logic [rcm_pkg::WindowBits-1:0] count_plus;
  logic [rcm_pkg::WindowBits-1:0] limit;
  logic                           window_end;
  logic [rcm_pkg::WindowBits:0]   div_sh;
  logic [rcm_pkg::WindowBits:0]   div_diff;
  logic                           div_ge;
  logic [rcm_pkg::RootBits+2:0]   sq_sh;
  logic [rcm_pkg::RootBits+2:0]   sq_trial;
  logic [rcm_pkg::RootBits+2:0]   sq_diff;
  logic                           sq_ge;
  logic [rcm_pkg::ProdBits-5:0]   amps;

  assign cw       = rcm_pkg::micro_word(pc);
  assign take     = sample.valid && sample.ready;
  assign out_free = !out_valid || result.ready;

  assign sample.ready       = (cw.op == rcm_pkg::OP_TAKE);
  assign result.valid       = out_valid;
  assign result.rms_current = out_current;
  assign result.rms_counts  = out_counts;

  // Offset filter step and offset-removed sample in Q13.4
  always_comb begin
    scaled      = {sample_reg, {rcm_pkg::FracBits{1'b0}}};
    diff        = $signed({1'b0, scaled}) - $signed({1'b0, dc_offset});
    offset_step = diff >>> rcm_pkg::AdcBits;
    offset_sum  = {1'b0, dc_offset} + offset_step;
    filt        = (rcm_pkg::MagBits+1)'(diff >>> (rcm_pkg::FracBits - 4));
    filt_abs    = filt[rcm_pkg::MagBits] ? (rcm_pkg::MagBits+1)'(-filt) : filt;
  end

  // Shared multiplier operands: magnitude squared, or root times gain
  always_comb begin
    if (cw.op == rcm_pkg::OP_GAIN) begin
      mult_a = root;
      mult_b = current_gain;
    end else begin
      mult_a = rcm_pkg::RootBits'(mag);
      mult_b = rcm_pkg::GainBits'(mag);
    end
  end

  // Window bookkeeping: the sample count wraps, a zero window acts as one
  always_comb begin
    count_wide = {1'b0, sample_count} + 1'b1;
    count_plus = count_wide[rcm_pkg::WindowBits-1:0];
    limit      = (window_length == '0) ? rcm_pkg::WindowBits'(1) : window_length;
    window_end = (count_plus == '0) || (count_plus >= limit);
  end

  // One restoring divide step and one square-root bit-pair step
  always_comb begin
    div_sh   = {rem, quo[rcm_pkg::SumBits-1]};
    div_ge   = div_sh >= {1'b0, divisor};
    div_diff = div_sh - {1'b0, divisor};
    sq_sh    = {sq_rem, quo[rcm_pkg::SumBits-1 -: 2]};
    sq_trial = {1'b0, root, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_diff  = sq_sh - sq_trial;
    amps     = product[rcm_pkg::ProdBits-1:4];
  end

  // Step counter sequencing
  always_comb begin
    pc_next = pc;
    case (cw.cond)
      rcm_pkg::COND_NEXT:     pc_next = cw.target;
      rcm_pkg::COND_WAIT_IN:  pc_next = take ? cw.target : pc;
      rcm_pkg::COND_LOOP:     pc_next = (iter != '0) ? pc : cw.target;
      rcm_pkg::COND_END:      pc_next = window_end ? cw.target : rcm_pkg::StepTake;
      rcm_pkg::COND_WAIT_OUT: pc_next = out_free ? cw.target : pc;
      default:                pc_next = rcm_pkg::StepTake;
    endcase
  end

  // Sequencer, datapath and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= rcm_pkg::StepTake;
      iter          <= '0;
      out_valid     <= 1'b0;
      window_length <= rcm_pkg::WindowReset;
      current_gain  <= rcm_pkg::GainReset;
      dc_offset     <= rcm_pkg::OffsetReset;
      square_sum    <= '0;
      sample_count  <= '0;
    end else begin
      pc <= pc_next;

      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          rcm_pkg::RegWindowLength: window_length <= cfg_data[rcm_pkg::WindowBits-1:0];
          rcm_pkg::RegCurrentGain:  current_gain  <= cfg_data[rcm_pkg::GainBits-1:0];
          default: ;
        endcase
      end

      // Result request leaves when the sink takes it, unless the load step refills it
      if (out_valid && result.ready && (cw.op != rcm_pkg::OP_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (cw.op)
        rcm_pkg::OP_TAKE: begin
          if (take) begin
            sample_reg <= sample.adc_sample;
          end
        end
        rcm_pkg::OP_OFFSET: begin
          dc_offset <= offset_sum[rcm_pkg::OffsetBits-1:0];
        end
        rcm_pkg::OP_MAG: begin
          mag <= filt_abs[rcm_pkg::MagBits-1:0];
        end
        rcm_pkg::OP_SQUARE: begin
          product <= mult_a * mult_b;
        end
        rcm_pkg::OP_ACCUM: begin
          square_sum   <= square_sum + rcm_pkg::SumBits'(product);
          sample_count <= count_plus;
        end
        rcm_pkg::OP_DIV_INIT: begin
          quo          <= square_sum;
          rem          <= '0;
          divisor      <= (sample_count == '0) ? rcm_pkg::WindowBits'(1) : sample_count;
          iter         <= rcm_pkg::IterBits'(rcm_pkg::DivSteps - 1);
          square_sum   <= '0;
          sample_count <= '0;
        end
        rcm_pkg::OP_DIV_STEP: begin
          rem  <= div_ge ? div_diff[rcm_pkg::WindowBits-1:0] : div_sh[rcm_pkg::WindowBits-1:0];
          quo  <= {quo[rcm_pkg::SumBits-2:0], div_ge};
          iter <= iter - 1'b1;
        end
        rcm_pkg::OP_SQRT_INIT: begin
          sq_rem <= '0;
          root   <= '0;
          iter   <= rcm_pkg::IterBits'(rcm_pkg::SqrtSteps - 1);
        end
        rcm_pkg::OP_SQRT_STEP: begin
          sq_rem <= sq_ge ? sq_diff[rcm_pkg::RootBits:0] : sq_sh[rcm_pkg::RootBits:0];
          root   <= {root[rcm_pkg::RootBits-2:0], sq_ge};
          quo    <= {quo[rcm_pkg::SumBits-3:0], 2'b00};
          iter   <= iter - 1'b1;
        end
        rcm_pkg::OP_GAIN: begin
          product <= mult_a * mult_b;
        end
        rcm_pkg::OP_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_current <= (|amps[rcm_pkg::ProdBits-5:rcm_pkg::CurrentBits])
                         ? '1 : amps[rcm_pkg::CurrentBits-1:0];
            out_counts  <= (|root[rcm_pkg::RootBits-1:rcm_pkg::CountsBits])
                         ? '1 : root[rcm_pkg::CountsBits-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // An accepted sample always moves the sequencer to the offset update.
  assert property (@(posedge clk) disable iff (rst)
    take |=> (pc == rcm_pkg::StepOffset))
    else $error("accepted sample did not start the offset update");

  // The divisor is never zero while the divide runs.
  assert property (@(posedge clk) disable iff (rst)
    (pc == rcm_pkg::StepDiv) |-> (divisor != '0))
    else $error("zero divisor during mean division");

  // Starting the divide clears the accumulator and the sample count.
  assert property (@(posedge clk) disable iff (rst)
    (pc == rcm_pkg::StepDivInit) |=> (square_sum == '0) && (sample_count == '0))
    else $error("window state not cleared at end of window");

  // A new result request appears only out of the load step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(pc) == rcm_pkg::StepEmit))
    else $error("result loaded outside the load step");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench of the RMS current meter core with its own windowed-RMS predictor.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [rcm_pkg::CurrentBits-1:0] amps;
    logic [rcm_pkg::CountsBits-1:0]  counts;
  } rms_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [rcm_pkg::CfgIdxBits-1:0] cfg_index;
  logic [rcm_pkg::CfgBits-1:0]    cfg_data;

  rcm_sample_if smp();
  rcm_result_if res();

  rms_current_meter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp),
    .result    (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Samples still to be offered and RMS results still to arrive.
  logic [rcm_pkg::AdcBits-1:0] sample_q[$];
  rms_t                        rms_expected_q[$];

  // Predictor copy of the meter state and of its registers.
  longint            meter_offset;
  longint unsigned   meter_sum;
  logic [15:0]       meter_count;
  logic [rcm_pkg::WindowBits-1:0] cfg_window;
  logic [rcm_pkg::GainBits-1:0]   cfg_gain;

  int   err_count;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   hold_gen;
  int   hold_len;
  rms_t drv_rms;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous overall limit on the run.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Advances the meter by one sample; returns 1 when the sample closes a window.
  function automatic bit predict_rms(input logic [rcm_pkg::AdcBits-1:0] adc, output rms_t rec);
    longint          scaled;
    longint          filt;
    longint unsigned mag;
    longint unsigned root;
    longint unsigned amps;
    longint unsigned n;
    int unsigned     limit;
    scaled = longint'(adc) << rcm_pkg::FracBits;
    meter_offset = meter_offset + ((scaled - meter_offset) >>> rcm_pkg::AdcBits);
    filt = (scaled - meter_offset) >>> (rcm_pkg::FracBits - 4);
    mag = (filt < 0) ? -filt : filt;
    meter_sum = meter_sum + mag * mag;
    meter_count = meter_count + 16'd1;
    limit = (cfg_window == 0) ? 1 : cfg_window;
    rec = '0;
    if (meter_count != 0 && meter_count < limit) return 1'b0;
    n = (meter_count == 0) ? 1 : meter_count;
    root = int_sqrt(meter_sum / n);
    amps = (root * cfg_gain) >> 4;
    rec.amps = (amps > 64'hFFFF_FFFF) ? '1 : amps[31:0];
    rec.counts = (root > 64'hFFFF) ? '1 : root[15:0];
    meter_sum = 0;
    meter_count = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    err_count++;
    $display("mismatch %s: got %0h, expected %0h at %0t ns", what, got, want, $time);
  endtask

  // Sample driver: offers queued requests, predicts each one that is taken.
  always @(posedge clk) begin
    if (rst) begin
      smp.valid <= 1'b0;
      smp.adc_sample <= '0;
    end else begin
      if (smp.valid && smp.ready) begin
        if (predict_rms(smp.adc_sample, drv_rms)) rms_expected_q.push_back(drv_rms);
      end
      if (!smp.valid || smp.ready) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          smp.valid <= 1'b1;
          smp.adc_sample <= sample_q.pop_front();
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready generator with an optional long hold-off.
  int hold_seen;
  int hold_left;
  rms_t mon_want;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (rms_expected_q.size() == 0) begin
          report_mismatch("result request with nothing pending", res.rms_current, 0);
        end else begin
          mon_want = rms_expected_q.pop_front();
          if (res.rms_current !== mon_want.amps)
            report_mismatch("rms_current", res.rms_current, mon_want.amps);
          if (res.rms_counts !== mon_want.counts)
            report_mismatch("rms_counts", res.rms_counts, mon_want.counts);
        end
      end
      if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        hold_left = hold_len;
        res.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left = hold_left - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Register write while the meter is idle; the predictor copy follows it.
  task automatic write_reg(input logic [rcm_pkg::CfgIdxBits-1:0] idx,
                           input logic [rcm_pkg::CfgBits-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rcm_pkg::RegWindowLength) cfg_window = data[rcm_pkg::WindowBits-1:0];
    else cfg_gain = data[rcm_pkg::GainBits-1:0];
  endtask

  // Writes the window length with random bits above the register width.
  task automatic write_window(input int unsigned wl);
    logic [rcm_pkg::CfgBits-1:0] d;
    d = rcm_pkg::CfgBits'($urandom);
    d[rcm_pkg::WindowBits-1:0] = wl[rcm_pkg::WindowBits-1:0];
    write_reg(rcm_pkg::RegWindowLength, d);
  endtask

  // Waits until every request is taken and every result has come, then lets
  // the sequencer finish any sample still in flight.
  task automatic settle();
    while (sample_q.size() != 0 || smp.valid || rms_expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Mix of full-range codes, rail values and codes close to mid-scale.
  function automatic logic [rcm_pkg::AdcBits-1:0] next_adc_sample();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 6) return '0;
    if (k == 7) return '1;
    if (k >= 8) return rcm_pkg::AdcBits'($urandom_range(2032, 2064));
    return rcm_pkg::AdcBits'($urandom);
  endfunction

  task automatic queue_samples(input int n);
    for (int i = 0; i < n; i++) sample_q.push_back(next_adc_sample());
  endtask

  function automatic logic [rcm_pkg::CfgBits-1:0] pick_gain();
    int unsigned k;
    k = $urandom_range(0, 7);
    if (k == 0) return '0;
    if (k == 1) return 24'hFF_FFFF;
    if (k <= 4) return rcm_pkg::CfgBits'($urandom_range(0, 65535));
    return rcm_pkg::CfgBits'($urandom);
  endfunction

  // Stimulus sequence.
  int unsigned wl;
  int unsigned wl_eff;
  int          sent;
  int          batch;
  int          k;
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_count = 0;
    hold_gen = 0;
    hold_len = 0;
    tx_idle_pct = 38;
    rx_idle_pct = 69;
    meter_offset = longint'(rcm_pkg::OffsetReset);
    meter_sum = 0;
    meter_count = 0;
    cfg_window = rcm_pkg::WindowReset;
    cfg_gain = rcm_pkg::GainReset;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One result per sample, full gain: rail samples drive the current into saturation.
    write_window(1);
    write_reg(rcm_pkg::RegCurrentGain, 24'hFF_FFFF);
    sample_q.push_back(12'd0);
    sample_q.push_back(12'd4095);
    sample_q.push_back(12'd2048);
    sample_q.push_back(12'd4095);
    sample_q.push_back(12'd0);
    settle();

    // Zero gain gives zero current whatever the counts.
    write_reg(rcm_pkg::RegCurrentGain, '0);
    sample_q.push_back(12'd4095);
    sample_q.push_back(12'd0);
    settle();

    // A zero window length behaves as one.
    write_window(0);
    write_reg(rcm_pkg::RegCurrentGain, rcm_pkg::CfgBits'(rcm_pkg::GainReset));
    sample_q.push_back(12'd1);
    sample_q.push_back(12'd4094);
    settle();

    // Longest window, then lowered mid-window so the next sample closes it early.
    write_window(16'hFFFF);
    for (int i = 0; i < 8; i++) sample_q.push_back((i % 2 == 0) ? 12'd4095 : 12'd0);
    settle();
    write_window(3);
    sample_q.push_back(next_adc_sample());
    settle();

    write_window(4);
    write_reg(rcm_pkg::RegCurrentGain, pick_gain());
    queue_samples(4);
    settle();

    // Random windows in three idling modes.
    for (int mode = 0; mode < 3; mode++) begin
      if (mode == 0) begin
        tx_idle_pct = 38;
        rx_idle_pct = 69;
      end else if (mode == 1) begin
        tx_idle_pct = 69;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      sent = 0;
      while (sent < 270) begin
        k = $urandom_range(0, 19);
        if (k == 0) wl = 0;
        else if (k == 1) wl = $urandom_range(20, 60);
        else wl = $urandom_range(1, 8);
        wl_eff = (wl == 0) ? 1 : wl;
        write_window(wl);
        write_reg(rcm_pkg::RegCurrentGain, pick_gain());
        batch = wl_eff * $urandom_range(1, 3) + $urandom_range(0, wl_eff - 1);
        if (sent == 0 && mode == 0) begin
          // Receiver holds off for a long stretch while the sender keeps offering.
          write_window(1);
          batch = 30;
          hold_len = 400;
          hold_gen = hold_gen + 1;
          queue_samples(batch);
        end else if (sent == 0 && mode == 1) begin
          // Sender pauses mid-window until every pending result has come.
          queue_samples(batch / 2);
          settle();
          queue_samples(batch - batch / 2);
        end else begin
          queue_samples(batch);
        end
        sent = sent + batch;
        settle();
      end
    end

    settle();
    if (err_count == 0 && rms_expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
